// ===== rtl/assert_macros.svh =====
// assertion macros used by timed_event_queue
// no dependencies; included by timed_event_queue, which carries concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/teq_pkg.sv =====
// types and codes for the timed event queue
// no dependencies; imported by timed_event_queue
package teq_pkg;

  localparam int MODE_W   = 2;
  localparam int CODE_W   = 8;
  localparam int DATA_W   = 8;
  localparam int TICK_W   = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 4;

  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SERVICE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CODE_W-1:0] event_code;
    logic [DATA_W-1:0] event_data;
    logic [TICK_W-1:0] delay_ticks;
    logic              tick_due;
  } req_t;

  typedef struct packed {
    logic                fired;
    logic [CODE_W-1:0]   fired_event;
    logic [DATA_W-1:0]   fired_data;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } rsp_t;

  // one queue slot as held in the slot memory
  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic [DATA_W-1:0] event_data;
    logic [TICK_W-1:0] countdown;
  } entry_t;

endpackage

// ===== rtl/teq_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module teq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/timed_event_queue.sv =====
// Timed event queue: compacted list of pending events with tick countdowns.
// Requests arrive on req (valid/ready): add or update, cancel, or a service
// pass that optionally ages every countdown and pops the first expired entry.
// Every request yields exactly one response on rsp (valid/ready) carrying
// fired flag, expired event and data, status and occupancy after the op.
// cfg_we/cfg_wdata write event_limit; codes at or above it are refused.
// Slots live in one ram that is walked one entry per cycle:
//   search     reads each entry in turn; add and cancel stop early on a hit
//   close gap  moves each later entry down one slot after a cancel or a pop
//   response   loads the output register
// The queue takes no new request until these steps are done, since the
// single ram read port serves them all. req_ready is high only while idle.
// The response sits in an output register; a new request is taken while it
// waits, but the next response is held back until rsp is taken.
// Reset (synchronous) empties the queue and sets event_limit to 255;
// slot contents are not cleared and are never read before being written.
// Depends on teq_pkg, teq_ram and assert_macros.svh.
`include "assert_macros.svh"

module timed_event_queue
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [CODE_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]        state, state_next;
  logic [CODE_W-1:0] event_limit;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  req_t              op, op_next;
  rsp_t              res, res_next;
  logic [CNT_W-1:0]  rd_ptr, rd_ptr_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic              found, found_next;
  logic [IDX_W-1:0]  pos, pos_next;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  logic [TICK_W-1:0] cd_new;
  logic              rsp_load;
  rsp_t              rsp_word;

  teq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // countdown after an optional tick, saturating at zero
  assign cd_new = (op.tick_due && (rd_data.countdown != '0)) ?
                  rd_data.countdown - 1'b1 : rd_data.countdown;

  assign req_ready = (state == ST_IDLE);
  assign rsp_load  = (state == ST_OUT) && (!rsp_valid || rsp_ready);

  always_comb begin
    rsp_word           = res;
    rsp_word.occupancy = OCC_W'(entry_count);
  end

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    op_next          = op;
    res_next         = res;
    rd_ptr_next      = rd_ptr;
    pend_next        = pend;
    pend_idx_next    = pend_idx;
    found_next       = found;
    pos_next         = pos;
    wr_en            = 1'b0;
    wr_addr          = pend_idx;
    wr_data          = rd_data;
    rd_addr          = rd_ptr[IDX_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          op_next     = req;
          res_next    = '0;
          rd_ptr_next = '0;
          pend_next   = 1'b0;
          found_next  = 1'b0;
          if ((req.mode == MODE_ADD || req.mode == MODE_CANCEL) &&
              req.event_code >= event_limit) begin
            res_next.status = STATUS_INVALID;
            state_next      = ST_OUT;
          end else if (req.mode == MODE_ADD || req.mode == MODE_CANCEL ||
                       req.mode == MODE_SERVICE) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_OUT;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, check the previous one
        if (rd_ptr < entry_count) begin
          pend_next     = 1'b1;
          pend_idx_next = rd_ptr[IDX_W-1:0];
          rd_ptr_next   = rd_ptr + 1'b1;
        end else begin
          pend_next = 1'b0;
        end

        if (pend) begin
          if (op.mode == MODE_SERVICE) begin
            wr_en             = op.tick_due;
            wr_data.countdown = cd_new;
            if (cd_new == '0 && !found) begin
              found_next           = 1'b1;
              pos_next             = pend_idx;
              res_next.fired       = 1'b1;
              res_next.fired_event = rd_data.event_code;
              res_next.fired_data  = rd_data.event_data;
            end
          end else if (rd_data.event_code == op.event_code) begin
            pend_next = 1'b0;
            if (op.mode == MODE_ADD) begin
              wr_en              = 1'b1;
              wr_data.event_code = op.event_code;
              wr_data.event_data = op.event_data;
              wr_data.countdown  = op.delay_ticks;
              state_next         = ST_OUT;
            end else begin
              rd_ptr_next = CNT_W'(pend_idx) + 1'b1;
              state_next  = ST_SHIFT;
            end
          end
        end else if (rd_ptr >= entry_count) begin
          // search finished: no hit for add or cancel, or the end of a service pass
          priority if (op.mode == MODE_ADD) begin
            if (entry_count < DEPTH_CNT) begin
              wr_en              = 1'b1;
              wr_addr            = entry_count[IDX_W-1:0];
              wr_data.event_code = op.event_code;
              wr_data.event_data = op.event_data;
              wr_data.countdown  = op.delay_ticks;
              entry_count_next   = entry_count + 1'b1;
            end else begin
              res_next.status = STATUS_FULL;
            end
            state_next = ST_OUT;
          end else if (op.mode == MODE_CANCEL) begin
            res_next.status = STATUS_MISS;
            state_next      = ST_OUT;
          end else if (found) begin
            rd_ptr_next = CNT_W'(pos) + 1'b1;
            state_next  = ST_SHIFT;
          end else begin
            state_next = ST_OUT;
          end
        end
      end

      ST_SHIFT: begin
        // move each later entry down one slot
        wr_en = pend;
        if (rd_ptr < entry_count) begin
          pend_next     = 1'b1;
          pend_idx_next = IDX_W'(rd_ptr - 1'b1);
          rd_ptr_next   = rd_ptr + 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            entry_count_next = entry_count - 1'b1;
            state_next       = ST_OUT;
          end
        end
      end

      ST_OUT: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      event_limit <= 8'hFF;
      pend        <= 1'b0;
      found       <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      pend        <= pend_next;
      found       <= found_next;
      if (cfg_we) begin
        event_limit <= cfg_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    res      <= res_next;
    rd_ptr   <= rd_ptr_next;
    pend_idx <= pend_idx_next;
    pos      <= pos_next;
    if (rsp_load) begin
      rsp <= rsp_word;
    end
  end

  `ASSERT_AT(a_busy_after_transfer, clk, rst, req_valid && req_ready |=> state != ST_IDLE, "request transfer did not start an operation")
  `ASSERT_NEVER(a_shift_on_empty, clk, rst, state == ST_SHIFT && entry_count == '0, "gap closing with an empty queue")
  `ASSERT_AT(a_count_step, clk, rst, !$past(rst) && entry_count != $past(entry_count) |-> entry_count == $past(entry_count) + 1'b1 || entry_count == $past(entry_count) - 1'b1, "entry count moved by more than one")
  `ASSERT_NEVER(a_count_bound, clk, rst, entry_count > DEPTH_CNT, "entry count above queue depth")

endmodule
